>>> rtl/yuv2bgr_pkg.sv
`timescale 1ns / 1ps
// Package for the 4:2:0 block to BGR24 converter: chroma term ROMs,
// widths and the byte clamp. No dependencies.
package yuv2bgr_pkg;

    localparam int SampleWidth = 8;
    localparam int TermWidth   = 9;   // signed chroma term, |term| <= 226
    localparam int SumWidth    = 10;  // signed luma plus terms, -226..480
    localparam int RomDepth    = 1 << SampleWidth;
    localparam int ChromaMid   = 128;
    localparam int ByteMax     = 8'hFF;

    localparam int CB_TO_B_NUM = 1772;
    localparam int CB_TO_B_DEN = 1000;
    localparam int CB_TO_G_NUM = 34414;
    localparam int CB_TO_G_DEN = 100000;
    localparam int CR_TO_G_NUM = 71414;
    localparam int CR_TO_G_DEN = 100000;
    localparam int CR_TO_R_NUM = 1402;
    localparam int CR_TO_R_DEN = 1000;

    typedef logic [SampleWidth-1:0]      sample_t;
    typedef logic signed [TermWidth-1:0] term_t;
    typedef logic signed [SumWidth-1:0]  sum_t;
    typedef term_t                       term_rom_t [RomDepth];

    typedef enum logic [1:0] {
        SEL_CB_TO_B,
        SEL_CB_TO_G,
        SEL_CR_TO_G,
        SEL_CR_TO_R
    } term_sel_t;

    // coef * (code - 128), truncated toward zero; elaboration only
    function automatic term_t chroma_term(int idx, term_sel_t sel);
        int off;
        int mag;
        int prod;
        off = idx - ChromaMid;
        mag = (off < 0) ? -off : off;
        case (sel)
            SEL_CB_TO_B: prod = (CB_TO_B_NUM * mag) / CB_TO_B_DEN;
            SEL_CB_TO_G: prod = (CB_TO_G_NUM * mag) / CB_TO_G_DEN;
            SEL_CR_TO_G: prod = (CR_TO_G_NUM * mag) / CR_TO_G_DEN;
            SEL_CR_TO_R: prod = (CR_TO_R_NUM * mag) / CR_TO_R_DEN;
            default:     prod = 0;
        endcase
        if (off < 0)
            prod = -prod;
        return TermWidth'(prod);
    endfunction

    function automatic term_rom_t build_rom(term_sel_t sel);
        term_rom_t rom;
        for (int i = 0; i < RomDepth; i++)
        begin
            rom[i] = chroma_term(i, sel);
        end
        return rom;
    endfunction

    localparam term_rom_t CB_TO_B_ROM = build_rom(SEL_CB_TO_B);
    localparam term_rom_t CB_TO_G_ROM = build_rom(SEL_CB_TO_G);
    localparam term_rom_t CR_TO_G_ROM = build_rom(SEL_CR_TO_G);
    localparam term_rom_t CR_TO_R_ROM = build_rom(SEL_CR_TO_R);

    function automatic sample_t clamp_byte(sum_t v);
        sample_t res;
        if (v < 0)
            res = '0;
        else if (v > sum_t'(ByteMax))
            res = sample_t'(ByteMax);
        else
            res = v[SampleWidth-1:0];
        return res;
    endfunction

endpackage

>>> rtl/yuv420_block_to_bgr24.sv
`timescale 1ns / 1ps
// An accepted item moves from the input register into the result register, where
// it is held until it is taken.
// Throughput: one item per cycle with out_ready held high; the ROM lookup, add and
// clamp between the two registers set only the clock period.
// Reset (rst_n low, asynchronous) empties both stages; payload registers are not reset.
// Depends on yuv2bgr_pkg for the chroma term ROMs and the clamp.
module yuv420_block_to_bgr24
    import yuv2bgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t luma_top_left,
    input  sample_t luma_top_right,
    input  sample_t luma_bottom_left,
    input  sample_t luma_bottom_right,
    input  sample_t chroma_blue,
    input  sample_t chroma_red,

    output logic    out_valid,
    input  logic    out_ready,
    output sample_t blue_top_left,
    output sample_t green_top_left,
    output sample_t red_top_left,
    output sample_t blue_top_right,
    output sample_t green_top_right,
    output sample_t red_top_right,
    output sample_t blue_bottom_left,
    output sample_t green_bottom_left,
    output sample_t red_bottom_left,
    output sample_t blue_bottom_right,
    output sample_t green_bottom_right,
    output sample_t red_bottom_right
);

    localparam int NumPixels = 4;

    // ---------------------------------------------------------------
    // Handshake: the result register advances when it is empty or its
    // item is being taken; the input register advances into it. A new
    // item enters whenever the input register is empty or moving on;
    // hold the input while both registers are full and the result waits.
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic s1_advance;
    logic in_accept;

    assign out_advance = !out_valid_reg || out_ready;
    assign s1_advance  = out_advance;
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_accept   = in_valid && in_ready;
    assign out_valid   = out_valid_reg;

    // ---------------------------------------------------------------
    // Input register: hold the raw block until it moves on.
    // ---------------------------------------------------------------
    sample_t luma_reg [NumPixels];
    sample_t cb_reg;
    sample_t cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            luma_reg[0] <= luma_top_left;
            luma_reg[1] <= luma_top_right;
            luma_reg[2] <= luma_bottom_left;
            luma_reg[3] <= luma_bottom_right;
            cb_reg      <= chroma_blue;
            cr_reg      <= chroma_red;
        end
    end

    // ---------------------------------------------------------------
    // Conversion: four table lookups shared by all four pixels, then
    // one add and one clamp per channel.
    // ---------------------------------------------------------------
    term_t   add_b;
    term_t   cb_g;
    term_t   cr_g;
    term_t   add_r;
    sum_t    sub_g;
    sample_t blue_next  [NumPixels];
    sample_t green_next [NumPixels];
    sample_t red_next   [NumPixels];

    assign add_b = CB_TO_B_ROM[cb_reg];
    assign cb_g  = CB_TO_G_ROM[cb_reg];
    assign cr_g  = CR_TO_G_ROM[cr_reg];
    assign add_r = CR_TO_R_ROM[cr_reg];
    assign sub_g = sum_t'(cb_g) + sum_t'(cr_g);

    always_comb
    begin
        for (int px = 0; px < NumPixels; px++)
        begin
            blue_next[px]  = clamp_byte(sum_t'({2'b00, luma_reg[px]}) + sum_t'(add_b));
            green_next[px] = clamp_byte(sum_t'({2'b00, luma_reg[px]}) - sub_g);
            red_next[px]   = clamp_byte(sum_t'({2'b00, luma_reg[px]}) + sum_t'(add_r));
        end
    end

    // ---------------------------------------------------------------
    // Result register: drop the taken item, load the next one.
    // ---------------------------------------------------------------
    sample_t blue_reg  [NumPixels];
    sample_t green_reg [NumPixels];
    sample_t red_reg   [NumPixels];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign blue_top_left      = blue_reg[0];
    assign green_top_left     = green_reg[0];
    assign red_top_left       = red_reg[0];
    assign blue_top_right     = blue_reg[1];
    assign green_top_right    = green_reg[1];
    assign red_top_right      = red_reg[1];
    assign blue_bottom_left   = blue_reg[2];
    assign green_bottom_left  = green_reg[2];
    assign red_bottom_left    = red_reg[2];
    assign blue_bottom_right  = blue_reg[3];
    assign green_bottom_right = green_reg[3];
    assign red_bottom_right   = red_reg[3];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_s1_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("input stage lost an item while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance |=> out_valid_reg)
        else $error("item left input stage without reaching the output");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg && out_advance |=> !out_valid_reg)
        else $error("result appeared with no item behind it");

endmodule
